>>> rtl/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared transaction type passed from the parsing front end to the result
// back end through the event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package csvfs_pkg;

	localparam int unsigned SIZE_BITS = 16;

	// One entry per input byte that produced anything: an optional field
	// result followed by an optional end-of-text summary.
	typedef struct packed {
		logic                 has_elem;
		logic [SIZE_BITS-1:0] elem_offset;
		logic [SIZE_BITS-1:0] elem_size;
		logic                 has_sum;
		logic                 unclosed;
	} event_t;

endpackage

`default_nettype wire

>>> rtl/csvfs_front.sv
// ----------------------------------------------------------------------------
// CSV field splitter front end
// Classifies each byte, tracks the field and quote state and raises an event
// for every finished field and for the end of the text.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_front #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        data_byte,
	input  wire logic              last_byte,
	output logic                   ev_push,
	output csvfs_pkg::event_t      ev_data
);

	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_QUOTE   = 8'h22;

	typedef enum logic [3:0] {
		MODE_START  = 4'b0001,
		MODE_PLAIN  = 4'b0010,
		MODE_QUOTED = 4'b0100,
		MODE_AFTER  = 4'b1000
	} mode_t;

	typedef logic [POSITION_BITS-1:0] pos_t;

	function automatic logic is_ctrl(input logic [7:0] b);
		return (b < 8'h20) || (b == 8'h7F);
	endfunction

	function automatic logic is_lead(input logic [7:0] b);
		return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		return (b == CHAR_COMMA) || (b == CHAR_NEWLINE);
	endfunction

	mode_t mode_q, mode_d;
	pos_t  pos_q, pos_d;
	pos_t  head_q, head_d;
	pos_t  kept_q, kept_d;
	logic  parity_q, parity_d;
	logic  in_run_q, in_run_d;
	logic  trail_q, trail_d;
	logic  emit;
	logic  do_after;
	pos_t  size_full;

	always_comb begin
		mode_d   = mode_q;
		head_d   = head_q;
		kept_d   = kept_q;
		parity_d = parity_q;
		in_run_d = in_run_q;
		trail_d  = trail_q;
		pos_d    = pos_q + pos_t'(1);
		emit     = 1'b0;
		do_after = 1'b0;

		unique case (mode_q)
			MODE_START: begin
				if (is_ctrl(data_byte) && (data_byte != CHAR_NEWLINE)) begin
					// Leading control bytes other than newline are skipped.
				end else if (data_byte == CHAR_QUOTE) begin
					head_d   = pos_q + pos_t'(1);
					parity_d = 1'b1;
					in_run_d = 1'b1;
					mode_d   = MODE_QUOTED;
				end else if (is_delim(data_byte)) begin
					head_d = pos_q;
					kept_d = pos_q - pos_t'(1);
					emit   = 1'b1;
				end else begin
					head_d  = pos_q;
					kept_d  = pos_q;
					mode_d  = MODE_PLAIN;
					trail_d = is_lead(data_byte);
				end
			end
			MODE_PLAIN: begin
				if (trail_q) begin
					trail_d = 1'b0;
					if (!is_ctrl(data_byte)) kept_d = pos_q;
				end else if (is_delim(data_byte)) begin
					emit = 1'b1;
				end else begin
					trail_d = is_lead(data_byte);
					if (!is_ctrl(data_byte)) kept_d = pos_q;
				end
			end
			MODE_QUOTED: begin
				if (trail_q) begin
					trail_d = 1'b0;
				end else if (data_byte == CHAR_QUOTE) begin
					parity_d = ~parity_q;
					in_run_d = 1'b1;
				end else if (in_run_q && !parity_q) begin
					// The closing run ended on the previous byte.
					kept_d   = pos_q - pos_t'(2);
					in_run_d = 1'b0;
					mode_d   = MODE_AFTER;
					do_after = 1'b1;
				end else begin
					in_run_d = 1'b0;
					trail_d  = is_lead(data_byte);
				end
			end
			MODE_AFTER: begin
				do_after = 1'b1;
			end
			default: begin
				mode_d = MODE_START;
			end
		endcase

		if (do_after) begin
			if (trail_q) begin
				trail_d = 1'b0;
			end else if (is_delim(data_byte)) begin
				emit = 1'b1;
			end else begin
				trail_d = is_lead(data_byte);
			end
		end

		size_full = kept_d - head_d + pos_t'(1);

		ev_data.has_elem    = emit;
		ev_data.elem_offset = csvfs_pkg::SIZE_BITS'(head_d);
		ev_data.elem_size   = csvfs_pkg::SIZE_BITS'(size_full);

		if (emit) begin
			mode_d   = MODE_START;
			parity_d = 1'b0;
			in_run_d = 1'b0;
			trail_d  = 1'b0;
		end

		ev_data.has_sum  = last_byte;
		ev_data.unclosed = (mode_d == MODE_QUOTED) && !(in_run_d && !parity_d);

		// The end of the text returns the whole parser to its reset state.
		if (last_byte) begin
			mode_d   = MODE_START;
			pos_d    = '0;
			head_d   = '0;
			kept_d   = '0;
			parity_d = 1'b0;
			in_run_d = 1'b0;
			trail_d  = 1'b0;
		end

		ev_push = accept && (emit || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_START;
			pos_q    <= '0;
			head_q   <= '0;
			kept_q   <= '0;
			parity_q <= 1'b0;
			in_run_q <= 1'b0;
			trail_q  <= 1'b0;
		end else if (accept) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			head_q   <= head_d;
			kept_q   <= kept_d;
			parity_q <= parity_d;
			in_run_q <= in_run_d;
			trail_q  <= trail_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/csvfs_queue.sv
// ----------------------------------------------------------------------------
// CSV field splitter event queue
// Short first-in first-out store that decouples the parser from the result
// stage so that each can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire csvfs_pkg::event_t wr_data,
	output logic                   full,
	input  wire logic              rd_en,
	output csvfs_pkg::event_t      rd_data,
	output logic                   empty
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	csvfs_pkg::event_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= (wr_ptr_q == LAST_ADDR) ? '0 : wr_ptr_q + AW'(1);
			if (do_rd) rd_ptr_q <= (rd_ptr_q == LAST_ADDR) ? '0 : rd_ptr_q + AW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

>>> rtl/csvfs_back.sv
// ----------------------------------------------------------------------------
// CSV field splitter result stage
// Turns queued events into result transactions, keeping the field count and
// the longest field length, and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvfs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_empty,
	input  wire csvfs_pkg::event_t q_data,
	output logic                   q_pop,
	input  wire logic              pop,
	output logic                   empty,
	output logic                   is_summary,
	output logic [15:0]            element_offset,
	output logic [15:0]            element_size,
	output logic [15:0]            element_count,
	output logic [15:0]            longest_size,
	output logic                   unclosed_quote
);

	logic        out_valid_q;
	logic        elem_done_q;
	logic [15:0] count_q;
	logic [15:0] longest_q;
	logic        load;
	logic        load_elem;
	logic [15:0] count_inc;
	logic [15:0] longest_new;

	assign load      = (!out_valid_q || pop) && !q_empty;
	assign load_elem = q_data.has_elem && !elem_done_q;
	// An entry carrying both a field and a summary is read out in two turns.
	assign q_pop     = load && !(load_elem && q_data.has_sum);
	assign empty     = !out_valid_q;

	assign count_inc   = count_q + 16'd1;
	assign longest_new = (q_data.elem_size > longest_q) ? q_data.elem_size : longest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			elem_done_q <= 1'b0;
			count_q     <= '0;
			longest_q   <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				if (load_elem) begin
					count_q     <= count_inc;
					longest_q   <= longest_new;
					elem_done_q <= q_data.has_sum;
				end else begin
					count_q     <= '0;
					longest_q   <= '0;
					elem_done_q <= 1'b0;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (load_elem) begin
				is_summary     <= 1'b0;
				element_offset <= q_data.elem_offset;
				element_size   <= q_data.elem_size;
				element_count  <= count_inc;
				longest_size   <= longest_new;
				unclosed_quote <= 1'b0;
			end else begin
				is_summary     <= 1'b1;
				element_offset <= '0;
				element_size   <= '0;
				element_count  <= count_q;
				longest_size   <= longest_q;
				unclosed_quote <= q_data.unclosed;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/csv_field_splitter_core.sv
// ----------------------------------------------------------------------------
// CSV field splitter
// Results: a byte that ends a field has its result written to the event queue
// and then to the output register; the end-of-text summary follows it.
// Throughput: one byte per cycle while the event queue has room, set by the
// parser state update; a byte with a field and the summary gives two results.
// Reset: arst_n clears the parser, event queue and counters at once.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_splitter_core #(
	parameter int unsigned POSITION_BITS = 16,
	parameter int unsigned QUEUE_DEPTH   = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic             is_summary,
	output logic [15:0]      element_offset,
	output logic [15:0]      element_size,
	output logic [15:0]      element_count,
	output logic [15:0]      longest_size,
	output logic             unclosed_quote
);

	logic              accept;
	logic              ev_push;
	csvfs_pkg::event_t ev_data;
	csvfs_pkg::event_t q_data;
	logic              q_empty;
	logic              q_pop;

	assign accept = push && !full;

	csvfs_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.ev_push   (ev_push),
		.ev_data   (ev_data)
	);

	csvfs_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ev_push),
		.wr_data (ev_data),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	csvfs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_data         (q_data),
		.q_pop          (q_pop),
		.pop            (pop),
		.empty          (empty),
		.is_summary     (is_summary),
		.element_offset (element_offset),
		.element_size   (element_size),
		.element_count  (element_count),
		.longest_size   (longest_size),
		.unclosed_quote (unclosed_quote)
	);

endmodule

`default_nettype wire

>>> sim/csv_field_splitter_core_tb.sv
// ----------------------------------------------------------------------------
// CSV field splitter testbench
// Sends CSV texts one byte per transaction and predicts every field result
// and end-of-text summary. A scoreboard compares each popped result with the
// oldest prediction. The stimulus has a short directed part and then random
// records mixed with noise. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_splitter_core_tb;

	localparam int unsigned POS_BITS   = 16;
	localparam int unsigned TEXT_BYTES = 1850;
	localparam int unsigned MAX_REPORTS = 200;

	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	typedef enum logic [1:0] {
		FIELD_START,
		IN_PLAIN,
		IN_QUOTED,
		SEEK_DELIM
	} scan_mode_t;

	typedef struct packed {
		logic                            is_summary;
		logic [csvfs_pkg::SIZE_BITS-1:0] offset;
		logic [csvfs_pkg::SIZE_BITS-1:0] size;
		logic [csvfs_pkg::SIZE_BITS-1:0] count;
		logic [csvfs_pkg::SIZE_BITS-1:0] longest;
		logic                            unclosed;
	} field_result_t;

	class csv_field_predictor;
		logic [POS_BITS-1:0]             pos;
		logic [POS_BITS-1:0]             head;
		logic [POS_BITS-1:0]             kept;
		logic [csvfs_pkg::SIZE_BITS-1:0] count;
		logic [csvfs_pkg::SIZE_BITS-1:0] longest;
		scan_mode_t                      mode;
		bit                              parity;
		bit                              in_run;
		bit                              hidden;
		field_result_t                   expected_fields[$];
		int unsigned                     failures;

		function new();
			failures = 0;
			clear_text();
		endfunction

		static function bit is_ctrl(logic [7:0] b);
			return b < 8'h20 || b == 8'h7F;
		endfunction

		static function bit is_lead(logic [7:0] b);
			return (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
		endfunction

		static function bit is_delim(logic [7:0] b);
			return b == CH_COMMA || b == CH_NL;
		endfunction

		function void end_field();
			mode   = FIELD_START;
			parity = 1'b0;
			in_run = 1'b0;
			hidden = 1'b0;
		endfunction

		function void clear_text();
			pos     = '0;
			head    = '0;
			kept    = '0;
			count   = '0;
			longest = '0;
			end_field();
		endfunction

		function void emit_field();
			logic [POS_BITS-1:0] span;
			field_result_t       r;
			span  = kept - head + 1'b1;
			count = count + 1'b1;
			if (csvfs_pkg::SIZE_BITS'(span) > longest)
				longest = csvfs_pkg::SIZE_BITS'(span);
			r.is_summary = 1'b0;
			r.offset     = csvfs_pkg::SIZE_BITS'(head);
			r.size       = csvfs_pkg::SIZE_BITS'(span);
			r.count      = count;
			r.longest    = longest;
			r.unclosed   = 1'b0;
			expected_fields.push_back(r);
			end_field();
		endfunction

		// After a closed quoted field only a delimiter matters, but a lead
		// byte still hides the byte that follows it.
		function void seek_delim(logic [7:0] b);
			if (hidden)
				hidden = 1'b0;
			else if (is_delim(b))
				emit_field();
			else if (is_lead(b))
				hidden = 1'b1;
		endfunction

		function void note_byte(logic [7:0] b, logic final_flag);
			field_result_t summary;
			bit            closed;
			closed = 1'b0;
			case (mode)
				FIELD_START: begin
					if (is_ctrl(b) && b != CH_NL) begin
					end else if (b == CH_QUOTE) begin
						head   = pos + 1'b1;
						parity = 1'b1;
						in_run = 1'b1;
						mode   = IN_QUOTED;
					end else begin
						head = pos;
						kept = pos - 1'b1;
						if (is_delim(b)) begin
							emit_field();
						end else begin
							mode   = IN_PLAIN;
							hidden = is_lead(b);
							kept   = pos;
						end
					end
				end
				IN_PLAIN: begin
					if (hidden) begin
						hidden = 1'b0;
					end else if (is_delim(b)) begin
						emit_field();
						closed = 1'b1;
					end else if (is_lead(b)) begin
						hidden = 1'b1;
					end
					if (!closed && !is_ctrl(b))
						kept = pos;
				end
				IN_QUOTED: begin
					if (hidden) begin
						hidden = 1'b0;
					end else if (b == CH_QUOTE) begin
						parity = !parity;
						in_run = 1'b1;
					end else if (in_run && !parity) begin
						// The closing run ended on the previous byte.
						kept   = pos - 2'd2;
						in_run = 1'b0;
						mode   = SEEK_DELIM;
						seek_delim(b);
					end else begin
						in_run = 1'b0;
						if (is_lead(b))
							hidden = 1'b1;
					end
				end
				default: begin
					seek_delim(b);
				end
			endcase
			pos = pos + 1'b1;
			if (final_flag) begin
				summary.is_summary = 1'b1;
				summary.offset     = '0;
				summary.size       = '0;
				summary.count      = count;
				summary.longest    = longest;
				summary.unclosed   = mode == IN_QUOTED && !(in_run && !parity);
				expected_fields.push_back(summary);
				clear_text();
			end
		endfunction

		function void report(string name, int unsigned want, int unsigned got);
			failures++;
			if (failures <= MAX_REPORTS)
				$error("%s: expected %0d, actual %0d", name, want, got);
		endfunction

		function void check_result(field_result_t got);
			field_result_t want;
			if (expected_fields.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$error("result popped with nothing expected: summary %0d count %0d",
						got.is_summary, got.count);
				return;
			end
			want = expected_fields.pop_front();
			if (got.is_summary !== want.is_summary)
				report("is_summary", want.is_summary, got.is_summary);
			if (got.offset !== want.offset)
				report("element_offset", want.offset, got.offset);
			if (got.size !== want.size)
				report("element_size", want.size, got.size);
			if (got.count !== want.count)
				report("element_count", want.count, got.count);
			if (got.longest !== want.longest)
				report("longest_size", want.longest, got.longest);
			if (got.unclosed !== want.unclosed)
				report("unclosed_quote", want.unclosed, got.unclosed);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic        is_summary;
	logic [15:0] element_offset;
	logic [15:0] element_size;
	logic [15:0] element_count;
	logic [15:0] longest_size;
	logic        unclosed_quote;

	csv_field_predictor splitter = new();
	logic [7:0]         text_buf[$];
	int unsigned        bytes_sent = 0;
	int unsigned        rx_hold = 0;
	bit                 tx_burst = 1'b0;
	bit                 rx_burst = 1'b0;
	field_result_t      seen;

	csv_field_splitter_core #(
		.POSITION_BITS(POS_BITS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.empty         (empty),
		.pop           (pop),
		.is_summary    (is_summary),
		.element_offset(element_offset),
		.element_size  (element_size),
		.element_count (element_count),
		.longest_size  (longest_size),
		.unclosed_quote(unclosed_quote)
	);

	initial begin
		forever #10 clk = !clk;
	end

	initial begin
		#60_000_000;
		$display("status: fail");
		$finish;
	end

	// Result side: every popped transaction goes to the scoreboard, then a
	// fresh stall is drawn.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			rx_hold = 0;
		end else begin
			if (pop && !empty) begin
				seen = {is_summary, element_offset, element_size, element_count,
					longest_size, unclosed_quote};
				splitter.check_result(seen);
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				rx_hold = rx_burst ? 0 : $urandom_range(0, 18);
			end else if (rx_hold != 0) begin
				rx_hold--;
			end
			pop <= (rx_hold == 0);
		end
	end

	task automatic send_byte(input logic [7:0] value, input logic final_flag);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, 18);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push      <= 1'b1;
		data_byte <= value;
		last_byte <= final_flag;
		@(posedge clk);
		while (full)
			@(posedge clk);
		splitter.note_byte(value, final_flag);
		bytes_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_byte(text_buf[i], i == text_buf.size() - 1);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (splitter.expected_fields.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] rand_ctrl();
		logic [7:0] v;
		v = 8'($urandom_range(0, 31));
		if (v == CH_NL)
			v = 8'h7F;
		return v;
	endfunction

	// One content byte, or a lead byte with the trail byte that it hides.
	function automatic void add_content();
		int unsigned sel;
		logic [7:0]  v;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			v = 8'($urandom_range(8'h30, 8'h7A));
		end else if (sel < 63) begin
			v = rand_ctrl();
		end else if (sel < 80) begin
			v = 8'($urandom_range(0, 1) ? $urandom_range(8'h81, 8'h9F) :
				$urandom_range(8'hE0, 8'hFC));
			text_buf.push_back(v);
			case ($urandom_range(0, 3))
				0: v = CH_COMMA;
				1: v = CH_QUOTE;
				2: v = CH_NL;
				default: v = 8'($urandom_range(0, 255));
			endcase
		end else if (sel < 92) begin
			v = 8'($urandom_range(8'h80, 8'hFF));
		end else begin
			v = CH_QUOTE;
		end
		text_buf.push_back(v);
	endfunction

	function automatic void add_plain();
		repeat ($urandom_range(0, 2)) text_buf.push_back(rand_ctrl());
		repeat ($urandom_range(0, 8)) add_content();
		repeat ($urandom_range(0, 2)) text_buf.push_back(rand_ctrl());
	endfunction

	function automatic void add_quoted();
		int unsigned sel;
		text_buf.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 8)) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				add_content();
			end else if (sel < 8) begin
				text_buf.push_back(CH_QUOTE);
				text_buf.push_back(CH_QUOTE);
			end else begin
				text_buf.push_back($urandom_range(0, 1) ? CH_COMMA : CH_NL);
			end
		end
		text_buf.push_back(CH_QUOTE);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) text_buf.push_back(CH_QUOTE);
		if ($urandom_range(0, 3) == 0)
			add_content();
	endfunction

	// Well-formed records with random content; the text may also end on an
	// unterminated field or inside an open quote.
	function automatic void build_text();
		int unsigned sel;
		repeat ($urandom_range(1, 3)) begin
			for (int f = $urandom_range(1, 4); f > 0; f--) begin
				sel = $urandom_range(0, 9);
				if (sel >= 6)
					add_quoted();
				else if (sel >= 1)
					add_plain();
				if (f > 1)
					text_buf.push_back(CH_COMMA);
			end
			text_buf.push_back(CH_NL);
		end
		case ($urandom_range(0, 5))
			0: begin
				add_plain();
				text_buf.push_back(8'h6B);
			end
			1: begin
				text_buf.push_back(CH_QUOTE);
				if ($urandom_range(0, 1)) begin
					text_buf.push_back(8'h81);
					text_buf.push_back(CH_QUOTE);
				end
				text_buf.push_back(8'h6B);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void build_noise();
		repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
	endfunction

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Skipped leading control byte, doubled quote inside a quoted field,
		// lead byte hiding a comma, trimmed trailing control byte, and empty
		// fields before a comma and before the final newline.
		text_buf = '{8'h01, CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, 8'h62, CH_QUOTE,
			CH_COMMA, 8'h81, CH_COMMA, 8'h63, 8'h1F, CH_COMMA, CH_COMMA, CH_NL};
		send_text();
		// Lead byte hiding a quote, then the text ends inside the open quote.
		text_buf = '{CH_QUOTE, 8'hE0, CH_QUOTE, 8'h71, 8'h78};
		send_text();
		// Extreme byte values in a field that is never terminated.
		text_buf = '{8'hFF, 8'h00, 8'h7F};
		send_text();
		// Empty quoted field whose closing run is followed by a lead byte.
		text_buf = '{CH_QUOTE, CH_QUOTE, 8'h9F, 8'h7A, CH_COMMA};
		send_text();
		wait_drained();

		while (bytes_sent < TEXT_BYTES) begin
			tx_burst = ($urandom_range(0, 5) == 0);
			text_buf.delete();
			if ($urandom_range(0, 4) == 0)
				build_noise();
			else
				build_text();
			send_text();
			if ($urandom_range(0, 19) == 0)
				wait_drained();
		end
		wait_drained();

		repeat (20) @(posedge clk);
		if (splitter.failures == 0 && splitter.expected_fields.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
